// ----- rtl/core/time_of_day_hms_counter_macros.svh -----
// Assertion macros for the time-of-day counter checker.
// No dependencies; included by the checker file.
`ifndef TIME_OF_DAY_HMS_COUNTER_MACROS_SVH
`define TIME_OF_DAY_HMS_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TODC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("time-of-day counter assertion failed");

// Next-cycle implication, disabled during reset.
`define TODC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("time-of-day counter assertion failed");

// Next-cycle implication that also checks across reset.
`define TODC_ASSERT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("time-of-day counter assertion failed");

`endif

// ----- rtl/core/todc_pkg.sv -----
// Package for the time-of-day counter: operation codes, constants and
// the payload structs passed between pipeline stages. No dependencies.
package todc_pkg;

    typedef enum logic [3:0] {
        FN_QUERY    = 4'd0,
        FN_TICK_UP  = 4'd1,
        FN_TICK_DN  = 4'd2,
        FN_ADD      = 4'd3,
        FN_SET_HOUR = 4'd4,
        FN_SET_MIN  = 4'd5,
        FN_SET_SEC  = 4'd6,
        FN_LOAD_HMS = 4'd7,
        FN_LOAD_DS  = 4'd8
    } t_func;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [4:0]  MAX_HOUR      = 5'd23;
    localparam logic [5:0]  MAX_MIN       = 6'd59;

    // delta is biased by 2^31 to make it unsigned; this is 2^31 mod one day
    localparam logic [16:0] DAY_BIAS = 17'(64'd2147483648 % 64'd86400);

    // floor(v / 675) = (v * RECIP_DAY) >> RECIP_DAY_SH, exact for v < 2^25
    localparam int          RECIP_DAY_SH = 35;
    localparam logic [25:0] RECIP_DAY    = 26'(((64'd1 << RECIP_DAY_SH) + 64'd674) / 64'd675);

    // floor(r / 60) = (r * RECIP_MIN) >> RECIP_MIN_SH, exact for r < 3600
    localparam int          RECIP_MIN_SH = 18;
    localparam logic [12:0] RECIP_MIN    = 13'(((64'd1 << RECIP_MIN_SH) + 64'd59) / 64'd60);

    // largest hour count a 17-bit seconds value can hold
    localparam int MAX_SPLIT_HOUR = (2**17 - 1) / 3600;

    typedef struct packed {
        logic [3:0]  func;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
        logic [16:0] day_sec;
        logic [31:0] ubias;
        logic [15:0] quot;
        logic [16:0] val;
        logic [5:0]  hour;
        logic [11:0] rest;
        logic [5:0]  minute;
    } t_work;

    typedef struct packed {
        logic [3:0] func;
        logic [4:0] hour_in;
        logic [5:0] minute_in;
        logic [5:0] second_in;
        logic [4:0] d_hour;
        logic [5:0] d_minute;
        logic [5:0] d_second;
    } t_prep;

endpackage

// ----- rtl/core/todc_prep.sv -----
// Front pipeline of the time-of-day counter: reduces the signed delta modulo
// one day and splits it (or a loaded seconds value) into h/m/s. Uses todc_pkg.
module todc_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_delta_seconds,
    input  logic [4:0]         i_hour_in,
    input  logic [5:0]         i_minute_in,
    input  logic [5:0]         i_second_in,
    input  logic [16:0]        i_day_seconds_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output todc_pkg::t_prep    o_item
);

    localparam int NSTG = 5;

    logic [NSTG-1:0]  r_vld;
    todc_pkg::t_work  r_work [NSTG];
    todc_pkg::t_work  n_work [NSTG];
    logic [NSTG:0]    w_rdy;
    logic             r_out_vld;
    todc_pkg::t_prep  r_out;
    todc_pkg::t_prep  n_out;

    logic [50:0] w_qprod;
    logic [31:0] w_qmul;
    logic [16:0] w_rem;
    logic [5:0]  w_hcnt;
    logic [16:0] w_hsub;
    logic [24:0] w_mprod;
    logic [11:0] w_msub;

    always_comb begin
        w_rdy[NSTG] = !r_out_vld || i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_out_vld;
    assign o_item      = r_out;

    always_comb begin
        // capture, bias delta to unsigned
        n_work[0]           = '0;
        n_work[0].func      = i_func;
        n_work[0].hour_in   = i_hour_in;
        n_work[0].minute_in = i_minute_in;
        n_work[0].second_in = i_second_in;
        n_work[0].day_sec   = i_day_seconds_in;
        n_work[0].ubias     = {~i_delta_seconds[31], i_delta_seconds[30:0]};

        // quotient by one day: (u >> 7) / 675
        n_work[1]      = r_work[0];
        w_qprod        = 51'(r_work[0].ubias[31:7]) * 51'(todc_pkg::RECIP_DAY);
        n_work[1].quot = 16'(w_qprod >> todc_pkg::RECIP_DAY_SH);

        // remainder, remove bias, or take the loaded seconds value
        n_work[2] = r_work[1];
        w_qmul    = 32'(r_work[1].quot) * 32'(todc_pkg::SECS_PER_DAY);
        w_rem     = 17'(r_work[1].ubias - w_qmul);
        if (r_work[1].func == todc_pkg::FN_LOAD_DS) begin
            n_work[2].val = r_work[1].day_sec;
        end else if (w_rem >= todc_pkg::DAY_BIAS) begin
            n_work[2].val = w_rem - todc_pkg::DAY_BIAS;
        end else begin
            n_work[2].val = w_rem + (todc_pkg::SECS_PER_DAY - todc_pkg::DAY_BIAS);
        end

        // hours by parallel compares
        n_work[3] = r_work[2];
        w_hcnt    = '0;
        for (int k = 1; k <= todc_pkg::MAX_SPLIT_HOUR; k++) begin
            if (r_work[2].val >= 17'(k * 3600)) begin
                w_hcnt = w_hcnt + 6'd1;
            end
        end
        w_hsub         = 17'(w_hcnt) * todc_pkg::SECS_PER_HOUR;
        n_work[3].hour = w_hcnt;
        n_work[3].rest = 12'(r_work[2].val - w_hsub);

        // minutes
        n_work[4]        = r_work[3];
        w_mprod          = 25'(r_work[3].rest) * 25'(todc_pkg::RECIP_MIN);
        n_work[4].minute = 6'(w_mprod >> todc_pkg::RECIP_MIN_SH);

        // seconds, hour clamp, tick offsets
        w_msub          = 12'(r_work[4].minute) * 12'(todc_pkg::SECS_PER_MIN);
        n_out.func      = r_work[4].func;
        n_out.hour_in   = r_work[4].hour_in;
        n_out.minute_in = r_work[4].minute_in;
        n_out.second_in = r_work[4].second_in;
        n_out.d_hour    = (r_work[4].hour > 6'(todc_pkg::MAX_HOUR)) ? 5'd0
                                                                    : 5'(r_work[4].hour);
        n_out.d_minute  = r_work[4].minute;
        n_out.d_second  = 6'(r_work[4].rest - w_msub);
        if (r_work[4].func == todc_pkg::FN_TICK_UP) begin
            n_out.d_hour   = 5'd0;
            n_out.d_minute = 6'd0;
            n_out.d_second = 6'd1;
        end else if (r_work[4].func == todc_pkg::FN_TICK_DN) begin
            n_out.d_hour   = todc_pkg::MAX_HOUR;
            n_out.d_minute = todc_pkg::MAX_MIN;
            n_out.d_second = todc_pkg::MAX_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
            if (w_rdy[NSTG]) begin
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_work[k] <= n_work[k];
            end
        end
        if (w_rdy[NSTG]) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/core/time_of_day_hms_counter.sv -----
// Time-of-day counter top level: hour/minute/second state and result register.
// Depends on todc_pkg and todc_prep.
//
// Input channel i_in_valid/o_in_ready carries one operation per transaction
// (query, tick up/down, add signed delta, set a field, load h/m/s, load
// seconds of day). Output channel o_out_valid/i_out_ready returns, for every
// transaction, the time after the operation as h/m/s and as seconds of day.
// Throughput is one transaction per cycle while the receiver does not
// stall: five stages and the output register of todc_prep reduce the delta
// modulo one day and split it into h/m/s, then a field-wise add with carries
// computes the next state combinationally from the current one, so consecutive
// transactions never wait on each other. Each stage holds its own valid bit, so
// bubbles close up while the receiver stalls; the input stalls only when every
// stage is full. The result register holds its transaction stable until taken.
// Reset (synchronous, active low) sets the time to 00:00:00 and empties
// the pipeline.
module time_of_day_hms_counter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_delta_seconds,
    input  logic [4:0]         i_hour_in,
    input  logic [5:0]         i_minute_in,
    input  logic [5:0]         i_second_in,
    input  logic [16:0]        i_day_seconds_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [4:0]         o_hour_out,
    output logic [5:0]         o_minute_out,
    output logic [5:0]         o_second_out,
    output logic [16:0]        o_day_seconds_out
);

    logic            w_p_valid;
    logic            w_p_ready;
    todc_pkg::t_prep w_p_item;
    logic            w_take;

    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;

    logic       r_out_vld;
    logic [4:0] r_o_hour;
    logic [5:0] r_o_minute;
    logic [5:0] r_o_second;

    logic [6:0] w_s_sum;
    logic [6:0] w_m_sum;
    logic [5:0] w_h_sum;
    logic       w_s_cy;
    logic       w_m_cy;
    logic [4:0] w_h_add;
    logic [5:0] w_m_add;
    logic [5:0] w_s_add;

    todc_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_delta_seconds  (i_delta_seconds),
        .i_hour_in        (i_hour_in),
        .i_minute_in      (i_minute_in),
        .i_second_in      (i_second_in),
        .i_day_seconds_in (i_day_seconds_in),
        .o_out_valid      (w_p_valid),
        .i_out_ready      (w_p_ready),
        .o_item           (w_p_item)
    );

    assign w_p_ready = !r_out_vld || i_out_ready;
    assign w_take    = w_p_valid && w_p_ready;

    // field-wise add of a reduced offset, one wrap at most per field
    always_comb begin
        w_s_sum = 7'(r_second) + 7'(w_p_item.d_second);
        w_s_cy  = (w_s_sum >= 7'(todc_pkg::SECS_PER_MIN));
        w_s_add = w_s_cy ? 6'(w_s_sum - 7'(todc_pkg::SECS_PER_MIN)) : 6'(w_s_sum);

        w_m_sum = 7'(r_minute) + 7'(w_p_item.d_minute) + 7'(w_s_cy);
        w_m_cy  = (w_m_sum >= 7'(todc_pkg::SECS_PER_MIN));
        w_m_add = w_m_cy ? 6'(w_m_sum - 7'(todc_pkg::SECS_PER_MIN)) : 6'(w_m_sum);

        w_h_sum = 6'(r_hour) + 6'(w_p_item.d_hour) + 6'(w_m_cy);
        w_h_add = (w_h_sum > 6'(todc_pkg::MAX_HOUR)) ? 5'(w_h_sum - 6'd24) : 5'(w_h_sum);
    end

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        unique case (w_p_item.func) inside
            todc_pkg::FN_TICK_UP, todc_pkg::FN_TICK_DN, todc_pkg::FN_ADD: begin
                n_hour   = w_h_add;
                n_minute = w_m_add;
                n_second = w_s_add;
            end
            todc_pkg::FN_LOAD_DS: begin
                n_hour   = w_p_item.d_hour;
                n_minute = w_p_item.d_minute;
                n_second = w_p_item.d_second;
            end
            todc_pkg::FN_SET_HOUR: begin
                if (w_p_item.hour_in <= todc_pkg::MAX_HOUR) begin
                    n_hour = w_p_item.hour_in;
                end
            end
            todc_pkg::FN_SET_MIN: begin
                if (w_p_item.minute_in <= todc_pkg::MAX_MIN) begin
                    n_minute = w_p_item.minute_in;
                end
            end
            todc_pkg::FN_SET_SEC: begin
                if (w_p_item.second_in <= todc_pkg::MAX_MIN) begin
                    n_second = w_p_item.second_in;
                end
            end
            todc_pkg::FN_LOAD_HMS: begin
                if (w_p_item.hour_in <= todc_pkg::MAX_HOUR
                    && w_p_item.minute_in <= todc_pkg::MAX_MIN
                    && w_p_item.second_in <= todc_pkg::MAX_MIN) begin
                    n_hour   = w_p_item.hour_in;
                    n_minute = w_p_item.minute_in;
                    n_second = w_p_item.second_in;
                end else begin
                    n_hour   = '0;
                    n_minute = '0;
                    n_second = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
            end
            if (w_p_ready) begin
                r_out_vld <= w_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_hour   <= n_hour;
            r_o_minute <= n_minute;
            r_o_second <= n_second;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_hour_out        = r_o_hour;
    assign o_minute_out      = r_o_minute;
    assign o_second_out      = r_o_second;
    assign o_day_seconds_out = 17'(r_o_hour) * todc_pkg::SECS_PER_HOUR
                             + 17'(r_o_minute) * todc_pkg::SECS_PER_MIN
                             + 17'(r_o_second);

endmodule

// ----- rtl/core/time_of_day_hms_counter_checker.sv -----
// Port-level checker for the time-of-day counter, bound to the top level.
// Depends on time_of_day_hms_counter_macros.svh.
`include "time_of_day_hms_counter_macros.svh"

module time_of_day_hms_counter_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [3:0]         i_func,
    input logic signed [31:0] i_delta_seconds,
    input logic [4:0]         i_hour_in,
    input logic [5:0]         i_minute_in,
    input logic [5:0]         i_second_in,
    input logic [16:0]        i_day_seconds_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [4:0]         o_hour_out,
    input logic [5:0]         o_minute_out,
    input logic [5:0]         o_second_out,
    input logic [16:0]        o_day_seconds_out
);

    `TODC_ASSERT_RAW(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    `TODC_ASSERT_IMP(a_fields_in_range, i_clk, i_rst_n, o_out_valid, o_hour_out <= 5'd23 && o_minute_out <= 6'd59 && o_second_out <= 6'd59 && o_day_seconds_out < 17'd86400)

    `TODC_ASSERT_NXT(a_valid_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `TODC_ASSERT_NXT(a_payload_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_hour_out) && $stable(o_minute_out) && $stable(o_second_out))

endmodule

bind time_of_day_hms_counter time_of_day_hms_counter_checker u_todc_chk (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for time_of_day_hms_counter: directed and random operations,
// checked in order against an internal time-of-day predictor.
// Depends on todc_pkg and the time_of_day_hms_counter RTL.
module tb_top;
    import todc_pkg::*;

    localparam logic [3:0] FN_UNUSED_LO = 4'd9;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] day_sec;
    } tod_t;

    class tod_scoreboard;
        logic [4:0] hour_q;
        logic [5:0] minute_q;
        logic [5:0] second_q;
        tod_t       expected_times[$];
        int         errors;
        int         checked;

        function new();
            hour_q   = '0;
            minute_q = '0;
            second_q = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int seconds_now();
            return int'(hour_q) * int'(SECS_PER_HOUR) + int'(minute_q) * int'(SECS_PER_MIN)
                + int'(second_q);
        endfunction

        function void load_seconds(int secs);
            int h;
            int rest;
            h        = secs / int'(SECS_PER_HOUR);
            rest     = secs % int'(SECS_PER_HOUR);
            hour_q   = (h > int'(MAX_HOUR)) ? 5'd0 : 5'(h);
            minute_q = 6'(rest / int'(SECS_PER_MIN));
            second_q = 6'(rest % int'(SECS_PER_MIN));
        endfunction

        function int pending();
            return expected_times.size();
        endfunction

        // advance the time of day by one accepted transaction
        function void note_operation(logic [3:0] func, logic signed [31:0] delta,
                                     logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                     logic [16:0] ds);
            longint sum;
            longint r;
            int     day;
            tod_t   t;
            day = int'(SECS_PER_DAY);
            case (func)
                FN_TICK_UP: load_seconds((seconds_now() + 1) % day);
                FN_TICK_DN: load_seconds((seconds_now() + day - 1) % day);
                FN_ADD: begin
                    sum = longint'(seconds_now()) + longint'(delta);
                    r   = sum % longint'(day);
                    if (r < 0) begin
                        r += day;
                    end
                    load_seconds(int'(r));
                end
                FN_SET_HOUR: if (h <= MAX_HOUR) hour_q = h;
                FN_SET_MIN:  if (m <= MAX_MIN) minute_q = m;
                FN_SET_SEC:  if (s <= MAX_MIN) second_q = s;
                FN_LOAD_HMS: begin
                    if (h <= MAX_HOUR && m <= MAX_MIN && s <= MAX_MIN) begin
                        hour_q   = h;
                        minute_q = m;
                        second_q = s;
                    end else begin
                        hour_q   = '0;
                        minute_q = '0;
                        second_q = '0;
                    end
                end
                FN_LOAD_DS: load_seconds(int'(ds));
                default: ;
            endcase
            t.hour    = hour_q;
            t.minute  = minute_q;
            t.second  = second_q;
            t.day_sec = 17'(seconds_now());
            expected_times.push_back(t);
        endfunction

        function void compare_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                         act_v);
            end
        endfunction

        function void check_result(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                   logic [16:0] ds);
            tod_t t;
            if (expected_times.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %0d:%0d:%0d (%0d s), nothing pending",
                         $time, h, m, s, ds);
                return;
            end
            t = expected_times.pop_front();
            checked++;
            compare_field("hour", 17'(t.hour), 17'(h));
            compare_field("minute", 17'(t.minute), 17'(m));
            compare_field("second", 17'(t.second), 17'(s));
            compare_field("day seconds", t.day_sec, ds);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [3:0]         i_func;
    logic signed [31:0] i_delta_seconds;
    logic [4:0]         i_hour_in;
    logic [5:0]         i_minute_in;
    logic [5:0]         i_second_in;
    logic [16:0]        i_day_seconds_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [4:0]         o_hour_out;
    logic [5:0]         o_minute_out;
    logic [5:0]         o_second_out;
    logic [16:0]        o_day_seconds_out;

    tod_scoreboard sb = new();

    bit burst_mode   = 1'b0;
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int n_sent       = 0;
    int n_directed   = 0;
    int n_holds      = 0;

    time_of_day_hms_counter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_delta_seconds   (i_delta_seconds),
        .i_hour_in         (i_hour_in),
        .i_minute_in       (i_minute_in),
        .i_second_in       (i_second_in),
        .i_day_seconds_in  (i_day_seconds_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hour_out        (o_hour_out),
        .o_minute_out      (o_minute_out),
        .o_second_out      (o_second_out),
        .o_day_seconds_out (o_day_seconds_out)
    );

    always #4 i_clk = ~i_clk;

    function int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task send_op(input logic [3:0] f, input logic signed [31:0] d, input logic [4:0] h,
                 input logic [5:0] m, input logic [5:0] s, input logic [16:0] ds);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= f;
        i_delta_seconds  <= d;
        i_hour_in        <= h;
        i_minute_in      <= m;
        i_second_in      <= s;
        i_day_seconds_in <= ds;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task send_random();
        int                 sel;
        logic [3:0]         f;
        logic signed [31:0] d;
        logic [4:0]         h;
        logic [5:0]         m;
        logic [5:0]         s;
        logic [16:0]        ds;
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            f = 4'($urandom_range(int'(FN_UNUSED_LO), int'(FN_UNUSED_HI)));
        end else if (sel < 30) begin
            f = ($urandom_range(0, 1) != 0) ? FN_TICK_UP : FN_TICK_DN;
        end else begin
            f = 4'($urandom_range(int'(FN_QUERY), int'(FN_LOAD_DS)));
        end
        case ($urandom_range(0, 3))
            0: d = $urandom;
            1: d = int'($urandom_range(0, 400)) - 200;
            2: d = (int'($urandom_range(0, 60)) - 30) * 86400 + int'($urandom_range(0, 4)) - 2;
            default: begin
                if ($urandom_range(0, 1) != 0) begin
                    d = 32'sh7fffffff - int'($urandom_range(0, 100000));
                end else begin
                    d = 32'sh80000000 + int'($urandom_range(0, 100000));
                end
            end
        endcase
        h = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(24, 31));
        m = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(60, 63));
        s = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(60, 63));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ds = 17'($urandom_range(0, 86399));
            5, 6: ds = 17'(int'($urandom_range(1, 24)) * 3600 - int'($urandom_range(0, 2)));
            7: ds = 17'($urandom_range(86390, 86409));
            default: ds = 17'($urandom_range(86400, 131071));
        endcase
        send_op(f, d, h, m, s, ds);
    endtask

    // transaction monitors feed the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_operation(i_func, i_delta_seconds, i_hour_in, i_minute_in, i_second_in,
                              i_day_seconds_in);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_hour_out, o_minute_out, o_second_out, o_day_seconds_out);
        end
    end

    // result side: random backpressure plus long hold-offs on request
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                n_holds++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
            @(posedge i_clk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = FN_QUERY;
        i_delta_seconds  = '0;
        i_hour_in        = '0;
        i_minute_in      = '0;
        i_second_in      = '0;
        i_day_seconds_in = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(FN_QUERY, 0, 0, 0, 0, 0);
        send_op(FN_TICK_DN, 0, 0, 0, 0, 0);
        send_op(FN_TICK_UP, 0, 0, 0, 0, 0);
        send_op(FN_ADD, 32'sh7fffffff, 0, 0, 0, 0);
        send_op(FN_ADD, 32'sh80000000, 0, 0, 0, 0);
        send_op(FN_ADD, -1, 0, 0, 0, 0);
        send_op(FN_ADD, -86401, 0, 0, 0, 0);
        send_op(FN_ADD, 86400, 0, 0, 0, 0);
        send_op(FN_SET_HOUR, 0, 23, 0, 0, 0);
        send_op(FN_SET_HOUR, 0, 24, 0, 0, 0);
        send_op(FN_SET_MIN, 0, 0, 59, 0, 0);
        send_op(FN_SET_MIN, 0, 0, 63, 0, 0);
        send_op(FN_SET_SEC, 0, 0, 0, 59, 0);
        send_op(FN_SET_SEC, 0, 0, 0, 60, 0);
        send_op(FN_TICK_UP, 0, 0, 0, 0, 0);
        send_op(FN_LOAD_HMS, 0, 12, 34, 56, 0);
        send_op(FN_LOAD_HMS, 0, 24, 0, 0, 0);
        send_op(FN_LOAD_HMS, 0, 0, 60, 0, 0);
        send_op(FN_LOAD_HMS, 0, 31, 63, 63, 0);
        send_op(FN_LOAD_DS, 0, 0, 0, 0, 86399);
        send_op(FN_LOAD_DS, 0, 0, 0, 0, 86400);
        send_op(FN_LOAD_DS, 0, 0, 0, 0, 131071);
        send_op(FN_SET_HOUR, 0, 31, 0, 0, 0);
        send_op(FN_UNUSED_LO, 0, 5, 5, 5, 0);
        send_op(FN_UNUSED_HI, 0, 0, 0, 0, 0);
        send_op(FN_LOAD_DS, 0, 0, 0, 0, 0);
        n_directed = n_sent;

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300 || i == 1200) begin
                burst_mode   = 1'b1;
                hold_request = 1'b1;
            end
            if (i == 420 || i == 1320) begin
                burst_mode = 1'b0;
            end
            no_idle = (i >= 800 && i < 900);
            send_random();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d transactions (%0d directed), %0d results checked,",
                 n_sent, n_directed, sb.checked);
        $display("         %0d receiver hold-offs of %0d cycles with the input backed up",
                 n_holds, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/todc_pkg.sv
rtl/core/todc_prep.sv
rtl/core/time_of_day_hms_counter.sv
rtl/core/time_of_day_hms_counter_checker.sv
tb/sv/tb_top.sv
